FILE: sv/ngram_dictionary_cover_marker_assert.svh
// Assertion macros for the n-gram cover marker, clocked on clk_i and held off in reset.
`ifndef NGRAM_DICTIONARY_COVER_MARKER_ASSERT_SVH
`define NGRAM_DICTIONARY_COVER_MARKER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define NDCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ndcm assertion failed");

// Next-cycle implication.
`define NDCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ndcm assertion failed");

`else

`define NDCM_ASSERT_IMP(lbl, ante, cons)
`define NDCM_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: sv/ndcm_pkg.sv
// Shared types and constants of the n-gram cover marker.
package ndcm_pkg;

  localparam int MAX_SPAN_DEF    = 8;
  localparam int NUM_ENTRIES_DEF = 64;
  localparam int TOKEN_BITS_DEF  = 20;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TOKEN = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  entry_index;
    logic [2:0]  entry_slot;
    logic [19:0] entry_token;
    logic [3:0]  entry_length;
    logic [19:0] token_id;
    logic        last_token;
  } ndcm_in_t;

  typedef struct packed {
    logic covered;
    logic last_mark;
  } ndcm_out_t;

  // Dictionary port controls.
  typedef struct packed {
    logic wr;   // slot write from an accepted write request
    logic clr;  // clear the length at the address (post-reset sweep)
    logic rd;   // read the row and length at the address
  } ndcm_dict_ctl_t;

endpackage

FILE: sv/ndcm_dict.sv
// Dictionary storage: token rows and entry lengths, one row read per cycle.
module ndcm_dict import ndcm_pkg::*; #(
  parameter int MAX_SPAN    = MAX_SPAN_DEF,
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int TOKEN_BITS  = TOKEN_BITS_DEF,
  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int PW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1
) (
  input  logic                                  clk_i,
  input  ndcm_dict_ctl_t                        ctl_i,
  input  ndcm_in_t                              req_i,
  input  logic [EW-1:0]                         addr_i,
  output logic [MAX_SPAN-1:0][TOKEN_BITS-1:0]   row_o,
  output logic [3:0]                            len_o
);

  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] tok_mem [NUM_ENTRIES];
  logic [3:0]                          len_mem [NUM_ENTRIES];

  logic [31:0]           idx_ext;
  logic [31:0]           slot_ext;
  logic [31:0]           tok_ext;
  logic                  idx_ok;
  logic                  slot_ok;
  logic [EW-1:0]         widx;
  logic [PW-1:0]         wslot;
  logic [TOKEN_BITS-1:0] wtok;

  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] row_q;
  logic [3:0]                          len_q;

  assign idx_ext  = 32'(req_i.entry_index);
  assign slot_ext = 32'(req_i.entry_slot);
  assign tok_ext  = 32'(req_i.entry_token);
  assign idx_ok   = idx_ext < 32'(NUM_ENTRIES);
  assign slot_ok  = slot_ext < 32'(MAX_SPAN);
  assign widx     = idx_ext[EW-1:0];
  assign wslot    = slot_ext[PW-1:0];
  assign wtok     = tok_ext[TOKEN_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      len_mem[addr_i] <= '0;
    end else if (ctl_i.wr && idx_ok) begin
      len_mem[widx] <= req_i.entry_length;
      if (slot_ok) begin
        tok_mem[widx][wslot] <= wtok;
      end
    end
    if (ctl_i.rd) begin
      row_q <= tok_mem[addr_i];
      len_q <= len_mem[addr_i];
    end
  end

  assign row_o = row_q;
  assign len_o = len_q;

endmodule

FILE: sv/ndcm_match.sv
// Shared compare unit: tests one dictionary row against the window and yields the marks it sets.
module ndcm_match import ndcm_pkg::*; #(
  parameter int MAX_SPAN   = MAX_SPAN_DEF,
  parameter int TOKEN_BITS = TOKEN_BITS_DEF,
  localparam int CW = $clog2(MAX_SPAN + 1),
  localparam int PW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1
) (
  input  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] row_i,
  input  logic [3:0]                          len_i,
  input  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] win_i,
  input  logic [CW-1:0]                       cnt_i,
  output logic [MAX_SPAN-1:0]                 hit_o
);

  logic       len_ok;
  logic       all_eq;
  logic [4:0] widx;

  always_comb begin
    widx   = '0;
    all_eq = 1'b1;
    hit_o  = '0;
    len_ok = (len_i != 4'd0) && (32'(len_i) <= 32'(MAX_SPAN)) &&
             (32'(len_i) <= 32'(cnt_i));
    if (len_ok) begin
      // Slot k of the entry lines up with the token len-1-k places back.
      for (int k = 0; k < MAX_SPAN; k++) begin
        if (32'(k) < 32'(len_i)) begin
          widx = 5'(len_i) - 5'(k) - 5'd1;
          if (row_i[k] != win_i[widx[PW-1:0]]) begin
            all_eq = 1'b0;
          end
        end
      end
    end
    for (int i = 0; i < MAX_SPAN; i++) begin
      hit_o[i] = len_ok && all_eq && (32'(i) < 32'(len_i));
    end
  end

endmodule

FILE: sv/ngram_dictionary_cover_marker.sv
// Top level of the n-gram cover marker: sequencer, token window and mark output.
//
//   channel  direction  handshake                 request type
//   in       input      in_valid_i / in_stall_o   ndcm_in_t
//   out      output     out_valid_o / out_stall_i ndcm_out_t
//
// After reset a sweep clears every entry length; no request is taken meanwhile.
// For a text token the scan reads one dictionary row per cycle from the single
// read port and runs it through the compare unit. A stalled output holds the
// sequencer in its emit step; up to MAX_SPAN marks leave per token, oldest first.
module ngram_dictionary_cover_marker import ndcm_pkg::*; #(
  parameter int MAX_SPAN    = MAX_SPAN_DEF,
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int TOKEN_BITS  = TOKEN_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ndcm_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ndcm_out_t out_req_o
);

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_SPAN + 1);
  localparam int PW = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
  localparam logic [EW-1:0] LAST_ENTRY = EW'(NUM_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT   = CW'(MAX_SPAN);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_EMIT
  } state_e;

  state_e                              state_q;
  logic [EW-1:0]                       ent_q;      // sweep / scan entry address
  logic                                pipe_vld_q; // row data from the dictionary is valid
  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] win_q;      // index 0 holds the newest token
  logic [MAX_SPAN-1:0]                 marks_q;
  logic [CW-1:0]                       seen_q;     // unemitted tokens in the window
  logic [CW-1:0]                       cnt_q;      // tokens in the window for this scan
  logic                                last_q;
  logic [CW-1:0]                       rem_q;      // marks still to emit
  logic [PW-1:0]                       ptr_q;      // window place of the next mark
  logic                                out_vld_q;
  ndcm_out_t                           out_q;

  logic                                in_acc;
  logic                                tok_acc;
  logic                                emit_go;
  logic [31:0]                         tok_ext;
  ndcm_dict_ctl_t                      dict_ctl;
  logic [MAX_SPAN-1:0][TOKEN_BITS-1:0] row;
  logic [3:0]                          row_len;
  logic [MAX_SPAN-1:0]                 hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign tok_acc     = in_acc && (in_req_i.cmd == CMD_TOKEN);
  assign tok_ext     = 32'(in_req_i.token_id);
  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;
  // A mark is loaded into the output register this cycle.
  assign emit_go     = (state_q == ST_EMIT) && (rem_q != '0) && (!out_vld_q || !out_stall_i);

  // Dictionary port: writes while idle, clearing sweep after reset, reads during the scan.
  assign dict_ctl.wr  = in_acc && (in_req_i.cmd == CMD_WRITE);
  assign dict_ctl.clr = (state_q == ST_CLEAR);
  assign dict_ctl.rd  = (state_q == ST_SCAN);

  ndcm_dict #(
    .MAX_SPAN    (MAX_SPAN),
    .NUM_ENTRIES (NUM_ENTRIES),
    .TOKEN_BITS  (TOKEN_BITS)
  ) u_dict (
    .clk_i  (clk_i),
    .ctl_i  (dict_ctl),
    .req_i  (in_req_i),
    .addr_i (ent_q),
    .row_o  (row),
    .len_o  (row_len)
  );

  ndcm_match #(
    .MAX_SPAN   (MAX_SPAN),
    .TOKEN_BITS (TOKEN_BITS)
  ) u_match (
    .row_i (row),
    .len_i (row_len),
    .win_i (win_q),
    .cnt_i (cnt_q),
    .hit_o (hit)
  );

  // Window tokens: payload only, shifted on each accepted text token.
  always_ff @(posedge clk_i) begin
    if (tok_acc) begin
      for (int i = MAX_SPAN - 1; i > 0; i--) begin
        win_q[i] <= win_q[i-1];
      end
      win_q[0] <= tok_ext[TOKEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      ent_q      <= '0;
      pipe_vld_q <= 1'b0;
      marks_q    <= '0;
      seen_q     <= '0;
      cnt_q      <= '0;
      last_q     <= 1'b0;
      rem_q      <= '0;
      ptr_q      <= '0;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      // Row data arrives in the cycle after its read address.
      pipe_vld_q <= (state_q == ST_SCAN);
      if (pipe_vld_q) begin
        marks_q <= marks_q | hit;
      end
      // Drop the output once the far side has taken it, unless a new mark follows.
      if (out_vld_q && !out_stall_i && !emit_go) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          if (ent_q == LAST_ENTRY) begin
            ent_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            ent_q <= ent_q + EW'(1);
          end
        end
        ST_IDLE: begin
          if (tok_acc) begin
            // Shift the new token in with a clear mark and start the scan.
            for (int i = MAX_SPAN - 1; i > 0; i--) begin
              marks_q[i] <= marks_q[i-1];
            end
            marks_q[0] <= 1'b0;
            cnt_q      <= seen_q + CW'(1);
            last_q     <= in_req_i.last_token;
            ent_q      <= '0;
            state_q    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (ent_q == LAST_ENTRY) begin
            ent_q   <= '0;
            state_q <= ST_WAIT;
          end else begin
            ent_q <= ent_q + EW'(1);
          end
        end
        ST_WAIT: begin
          // The last row is merged at this edge; plan the emission.
          ptr_q <= PW'(cnt_q - CW'(1));
          if (last_q) begin
            rem_q  <= cnt_q;
            seen_q <= '0;
          end else if (cnt_q == FULL_CNT) begin
            rem_q  <= CW'(1);
            seen_q <= FULL_CNT - CW'(1);
          end else begin
            rem_q  <= '0;
            seen_q <= cnt_q;
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (rem_q == '0) begin
            // A finished text leaves an empty window behind.
            if (last_q) begin
              marks_q <= '0;
            end
            state_q <= ST_IDLE;
          end else if (emit_go) begin
            out_q.covered   <= marks_q[ptr_q];
            out_q.last_mark <= last_q && (ptr_q == '0);
            out_vld_q       <= 1'b1;
            rem_q           <= rem_q - CW'(1);
            ptr_q           <= ptr_q - PW'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`include "ngram_dictionary_cover_marker_assert.svh"

  `NDCM_ASSERT_NXT(a_out_from_emit, !out_valid_o, !out_valid_o || $past(state_q) == ST_EMIT)
  `NDCM_ASSERT_NXT(a_token_starts_scan, tok_acc, state_q == ST_SCAN)
  `NDCM_ASSERT_IMP(a_seen_in_reach, state_q == ST_IDLE, seen_q < FULL_CNT)
  `NDCM_ASSERT_IMP(a_rem_bounded, state_q == ST_EMIT, rem_q <= cnt_q)

endmodule
